@@ rtl/cdeq_pkg.sv @@
// Shared types and constants for the circular deque block.
// No dependencies; every other file of the block but cdeq_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cdeq_pkg;

   // Storage geometry and field widths.
   localparam int DEPTH      = 8;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = 4;
   localparam int CAP_W      = 4;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      ACT_PUSH_REAR  = 2'd0,
      ACT_PUSH_FRONT = 2'd1,
      ACT_POP_REAR   = 2'd2,
      ACT_POP_FRONT  = 2'd3
   } action_type;

   // Completion codes carried by a response beat.
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic csr_write;
      logic load_read;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_pending;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/circular_deque_top.sv @@
// Channel    Handshake                  Payload
// request    start, busy (accept when   req_action, req_data
//            start and not busy)
// response   rsp_valid strobe, 1 cycle  rsp_value, rsp_status, rsp_occupancy
// csr        csr_valid, csr_ready       csr_data (capacity)
//
// A push, or a pop on an empty queue, is taken while idle and its response
// beat appears the cycle after; busy stays low, so one such beat per cycle.
// A pop that reads a slot raises busy in the ST_READ state while the registered
// read of the slot RAM completes; its response beat is registered from ST_READ.
// Synchronous reset empties the queue and sets the capacity to eight; the
// slot RAM is not cleared. The response side has no back-pressure.
//
// Top level of the circular deque; depends on cdeq_pkg, cdeq_ctrl, cdeq_dp.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_top
   import cdeq_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic [1:0]                   req_action,
   input  wire logic signed [DATA_WIDTH-1:0] req_data,
   output      logic                         rsp_valid,
   output      logic signed [DATA_WIDTH-1:0] rsp_value,
   output      logic [1:0]                   rsp_status,
   output      logic [CNT_W-1:0]             rsp_occupancy,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [CAP_W-1:0]             csr_data
);

   cmd_type       cmd;
   dp_status_type status;

   // Sequencing.
   cdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .status    (status),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Queue state and storage.
   cdeq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_action),
      .req_data      (req_data),
      .csr_data      (csr_data),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

`default_nettype wire

@@ rtl/cdeq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth come from its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(WORDS)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(WORDS)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cdeq_ctrl.sv @@
// Controller state machine of the circular deque: accepts beats and sequences
// the slot read of a pop. Depends on cdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_ctrl
   import cdeq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          csr_valid,
   input  wire dp_status_type status,
   output      logic          busy,
   output      logic          csr_ready,
   output      cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      busy          = 1'b0;
      csr_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_read = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready  = 1'b1;
            cmd.accept = start;
            if (start && status.read_pending) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            busy          = 1'b1;
            cmd.load_read = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.csr_write = csr_valid && csr_ready;
   end

endmodule

`default_nettype wire

@@ rtl/cdeq_dp.sv @@
// Datapath of the circular deque: pointers, count, capacity, slot RAM and
// the response registers. Depends on cdeq_pkg and cdeq_ram.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_dp
   import cdeq_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   input  wire logic [1:0]                   req_action,
   input  wire logic signed [DATA_WIDTH-1:0] req_data,
   input  wire logic [CAP_W-1:0]             csr_data,
   output      dp_status_type                status,
   output      logic                         rsp_valid,
   output      logic signed [DATA_WIDTH-1:0] rsp_value,
   output      logic [1:0]                   rsp_status,
   output      logic [CNT_W-1:0]             rsp_occupancy
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]             rsp_occ_ff, rsp_occ_in;

   logic [CAP_W-1:0]      cap_eff;
   logic                  is_pop;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Step an index forward, wrapping at the capacity.
   function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] nxt;
      nxt = CAP_W'(idx) + CAP_W'(1);
      return (nxt >= cap) ? '0 : IDX_W'(nxt);
   endfunction

   // Step an index backward, wrapping at the capacity.
   function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CAP_W-1:0] cap);
      return (idx == '0) ? IDX_W'(cap - CAP_W'(1)) : idx - IDX_W'(1);
   endfunction

   // Effective capacity: zero counts as one, anything above the depth saturates.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // A pop on a non-empty queue needs the ST_READ state for the slot read.
   assign is_pop              = (req_action == ACT_POP_REAR) || (req_action == ACT_POP_FRONT);
   assign status.read_pending = is_pop && (count_ff != '0);

   // Next-state logic for the pointers, count and response registers.
   always_comb begin
      cap_in        = cap_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (cmd.accept) begin
         case (req_action) inside
            ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               if (count_ff >= CNT_W'(cap_eff)) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_occ_in    = count_ff;
               end else begin
                  wr_en = 1'b1;
                  if (count_ff == '0) begin
                     head_in = '0;
                     tail_in = '0;
                     wr_addr = '0;
                  end else if (req_action == ACT_PUSH_REAR) begin
                     tail_in = wrap_up(tail_ff, cap_eff);
                     wr_addr = tail_in;
                  end else begin
                     head_in = wrap_down(head_ff, cap_eff);
                     wr_addr = head_in;
                  end
                  count_in      = count_ff + CNT_W'(1);
                  rsp_status_in = STATUS_DONE;
                  rsp_occ_in    = count_in;
               end
            end
            default: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_occ_in    = '0;
               end else begin
                  // The value arrives from the RAM's read register in the next cycle.
                  rd_en = 1'b1;
                  if (req_action == ACT_POP_REAR) begin
                     rd_addr = tail_ff;
                     tail_in = wrap_down(tail_ff, cap_eff);
                  end else begin
                     rd_addr = head_ff;
                     head_in = wrap_up(head_ff, cap_eff);
                  end
                  count_in = count_ff - CNT_W'(1);
                  if (count_in == '0) begin
                     head_in = '0;
                     tail_in = '0;
                  end
                  rsp_status_in = STATUS_DONE;
                  rsp_occ_in    = count_in;
               end
            end
         endcase
      end

      // Finish a pop with the slot just read.
      if (cmd.load_read) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_data;
      end

      // A capacity write also empties the queue.
      if (cmd.csr_write) begin
         cap_in   = csr_data;
         count_in = '0;
         head_in  = '0;
         tail_in  = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Slot storage.
   cdeq_ram #(
      .WIDTH (DATA_WIDTH),
      .WORDS (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

@@ rtl/cdeq_checker.sv @@
// Port-level checks of the circular deque, bound to circular_deque_top.
// Depends on cdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_checker
   import cdeq_pkg::*;
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic [1:0]                   req_action,
   input wire logic                         rsp_valid,
   input wire logic signed [DATA_WIDTH-1:0] rsp_value,
   input wire logic [1:0]                   rsp_status,
   input wire logic [CNT_W-1:0]             rsp_occupancy
);

   // An accepted push always answers on the next cycle.
   a_push_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_PUSH_REAR || req_action == ACT_PUSH_FRONT))
      |=> rsp_valid)
      else $error("push beat got no response on the next cycle");

   // An accepted pop either answers next cycle or holds busy for the read.
   a_pop_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_POP_REAR || req_action == ACT_POP_FRONT))
      |=> (rsp_valid != busy))
      else $error("pop beat neither answered nor started a read");

   // Busy in the read state is followed by a response beat with busy low.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("slot read did not complete in one cycle");

   // An empty pop reports all ones and an empty queue.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_value == -1 && rsp_occupancy == '0))
      else $error("empty pop response malformed");

   // A rejected push reports zero and never exceeds the storage depth.
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL)
      |-> (rsp_value == '0 && rsp_occupancy <= CNT_W'(DEPTH)))
      else $error("rejected push response malformed");

endmodule

bind circular_deque_top cdeq_checker u_cdeq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_value     (rsp_value),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire
